### sv/tstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_pkg: shared types and constants
// widths, item structs and the bar record passed from front to back
// ----------------------------------------------------------------------------
package tstg_pkg;
  // node indices are 16 bits wide, so every index stays below this bound
  localparam int MAX_NODES = 65536;
  localparam int ENTRIES = 36;
  localparam int AXES = 3;
  localparam logic [47:0] K_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [47:0] VAL_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] VAL_MIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic [17:0] base1;
    logic [17:0] base2;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [47:0] k;
    logic zero;
  } bar_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} front_state_t;
endpackage

### sv/tstg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_front: bar intake and axial stiffness
// forms k = area*modulus*2^16/length with a restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
module tstg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   first_node,
  input  logic [15:0]   second_node,
  input  logic [15:0]   cos_x,
  input  logic [15:0]   cos_y,
  input  logic [15:0]   cos_z,
  input  logic [31:0]   cross_area,
  input  logic [31:0]   elastic_modulus,
  input  logic [31:0]   bar_length,
  output logic          bar_valid,
  input  logic          bar_ready,
  output tstg_pkg::bar_t bar
);
  import tstg_pkg::*;

  front_state_t state, state_next;
  logic [31:0] area, modulus, len;
  logic [63:0] num;
  logic [32:0] rem;
  logic [79:0] quo;
  logic [6:0] cnt;
  bar_t rec;
  logic [32:0] trial;
  logic [79:0] dividend_bit_src;

  // dividend is num << 16, 80 bits, shifted in msb first
  assign dividend_bit_src = {num, 16'd0};
  assign trial = {rem[31:0], dividend_bit_src[7'd79 - cnt]};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) state_next = F_MUL;
      F_MUL:  state_next = rec.zero ? F_PUSH : F_DIV;
      F_DIV:  if (cnt == 7'd79) state_next = F_PUSH;
      F_PUSH: if (bar_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == F_IDLE);
    bar_valid = (state == F_PUSH);
    bar = rec;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: if (in_valid) begin
        area <= cross_area;
        modulus <= elastic_modulus;
        len <= bar_length;
        rec.base1 <= 18'(first_node) * 18'd3;
        rec.base2 <= 18'(second_node) * 18'd3;
        rec.cx <= cos_x;
        rec.cy <= cos_y;
        rec.cz <= cos_z;
        rec.zero <= (bar_length == 32'd0);
      end
      F_MUL: begin
        num <= 64'(area) * 64'(modulus);
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        if (rec.zero) rec.k <= K_MAX;
      end
      F_DIV: begin
        if (trial >= {1'b0, len}) begin
          rem <= trial - {1'b0, len};
          quo <= {quo[78:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[78:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd79) begin
          // the quotient register holds the full result only after this edge; use the final bit here
          if (quo[78:47] != 32'd0) rec.k <= K_MAX;
          else rec.k <= {quo[46:0], (trial >= {1'b0, len})};
        end
      end
      F_PUSH: ;
      default: ;
    endcase
  end
endmodule

### sv/tstg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_queue: two-entry bar queue
// decouples the divider from the triplet sequencer
// ----------------------------------------------------------------------------
module tstg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tstg_pkg::bar_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tstg_pkg::bar_t rd_data
);
  import tstg_pkg::*;

  bar_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

### sv/tstg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_back: triplet sequencer
// walks the nine axis pairs, scales k by the cosine product, emits four words each
// ----------------------------------------------------------------------------
module tstg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          bar_valid,
  output logic          bar_ready,
  input  tstg_pkg::bar_t bar,
  output logic          m_valid,
  input  logic          m_ready,
  output logic [17:0]   row_dof,
  output logic [17:0]   col_dof,
  output logic [47:0]   entry_value,
  output logic          length_zero,
  output logic          last_entry
);
  import tstg_pkg::*;

  // stage a: cosine product and sign; stage b: 64-bit partial products;
  // stage c: shift, round and saturate; then four emits per pair
  bar_t cur;
  logic busy;
  logic [1:0] t, r, sub;
  logic [3:0] phase; // 0..2 compute pipeline, 3 emit
  logic neg;
  logic [31:0] mag;
  logic [63:0] p_hi, p_lo;
  logic signed [47:0] v, nv;
  logic signed [15:0] cr, ct;
  logic signed [31:0] c;
  logic [67:0] q;
  logic lo_rem;
  logic [68:0] m;

  always_comb begin
    unique case (r)
      2'd0: cr = cur.cx;
      2'd1: cr = cur.cy;
      default: cr = cur.cz;
    endcase
    unique case (t)
      2'd0: ct = cur.cx;
      2'd1: ct = cur.cy;
      default: ct = cur.cz;
    endcase
  end
  assign c = cr * ct;
  assign q = {p_hi, 4'd0} + 68'(p_lo[63:28]);
  assign lo_rem = (p_lo[27:0] != 28'd0);
  assign m = {1'b0, q} + 69'(lo_rem);

  assign bar_ready = !busy;
  assign m_valid = busy && (phase == 4'd3);
  assign length_zero = cur.zero;
  assign last_entry = (t == 2'd2) && (r == 2'd2) && (sub == 2'd3);

  always_comb begin
    row_dof = sub[1] ? cur.base2 + 18'(r) : cur.base1 + 18'(r);
    col_dof = sub[0] ? cur.base2 + 18'(t) : cur.base1 + 18'(t);
    entry_value = (sub == 2'd1 || sub == 2'd2) ? nv : v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 4'd0;
    end else if (!busy) begin
      if (bar_valid) begin
        busy <= 1'b1;
        phase <= 4'd0;
        t <= 2'd0;
        r <= 2'd0;
        sub <= 2'd0;
      end
    end else if (phase != 4'd3) begin
      phase <= phase + 4'd1;
    end else if (m_ready) begin
      sub <= sub + 2'd1;
      if (sub == 2'd3) begin
        phase <= 4'd0;
        if (r == 2'd2) begin
          r <= 2'd0;
          if (t == 2'd2) busy <= 1'b0;
          else t <= t + 2'd1;
        end else r <= r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && bar_valid) cur <= bar;
    if (busy) begin
      unique case (phase)
        4'd0: begin
          neg <= c[31];
          mag <= c[31] ? 32'(-c) : 32'(c);
        end
        4'd1: begin
          p_hi <= 64'(mag) * 64'(cur.k[47:32]);
          p_lo <= 64'(mag) * 64'(cur.k[31:0]);
        end
        4'd2: begin
          if (neg) begin
            if (m > 69'h8000_0000_0000) v <= VAL_MIN;
            else v <= 48'(-m);
            nv <= (m >= 69'h8000_0000_0000) ? VAL_MAX : 48'(m);
          end else begin
            if (q > 68'h7FFF_FFFF_FFFF) begin
              v <= VAL_MAX;
              nv <= -VAL_MAX;
            end else begin
              v <= 48'(q);
              nv <= -48'(q);
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/truss_stiffness_triplet_gen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truss_stiffness_triplet_gen_top: 3d truss bar stiffness triplets
// one bar in, 36 (row, col, value) words out
// ----------------------------------------------------------------------------
// s_axis takes one bar word; m_axis gives 36 triplet words, tlast on the 36th.
// the front computes k with a bit-serial divider, which a zero length skips;
// s_axis_tready is high only while the front is idle.
// the bar then goes to a two-deep queue; the back sequencer loads it, then for
// each axis pair scales k and gives 4 words. the divider sets the sustained
// bar rate; front and back overlap, so a new bar is taken while triplets of
// the last one still go out. while m_axis_tready is high, words come one a
// cycle in groups of four, with a gap between axis pairs while the next
// product is computed.
// reset (rst, synchronous) empties the queue and idles both sides.
// a stall on m_axis holds the current word; the front finishes its bar and
// waits with it until the queue has room, taking no new bar meanwhile.
// ----------------------------------------------------------------------------
module truss_stiffness_triplet_gen_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_node, second_node, cos_x, cos_y, cos_z, cross_area, elastic_modulus, bar_length
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_dof, col_dof, entry_value, zero fill to 88 bits
  output logic [87:0]  m_axis_tdata,
  // length_zero
  output logic         m_axis_tuser,
  // last_entry
  output logic         m_axis_tlast
);
  import tstg_pkg::*;

  bar_t f_bar, q_bar;
  logic f_valid, f_ready, q_valid, q_ready;
  logic [17:0] row_dof, col_dof;
  logic [47:0] entry_value;

  tstg_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .first_node(s_axis_tdata[15:0]), .second_node(s_axis_tdata[31:16]),
    .cos_x(s_axis_tdata[47:32]), .cos_y(s_axis_tdata[63:48]),
    .cos_z(s_axis_tdata[79:64]), .cross_area(s_axis_tdata[111:80]),
    .elastic_modulus(s_axis_tdata[143:112]), .bar_length(s_axis_tdata[175:144]),
    .bar_valid(f_valid), .bar_ready(f_ready), .bar(f_bar)
  );

  tstg_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_bar),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_bar)
  );

  tstg_back u_back (
    .clk, .rst,
    .bar_valid(q_valid), .bar_ready(q_ready), .bar(q_bar),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .row_dof, .col_dof, .entry_value,
    .length_zero(m_axis_tuser), .last_entry(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, entry_value, col_dof, row_dof};
endmodule
